[design/sntk_pkg.sv]
// Shared constants and types for the sorted nearest-key table.
`default_nettype none

package sntk_pkg;

    localparam int KEY_BITS            = 32;
    localparam int DEF_TABLE_DEPTH     = 16;
    localparam int DEF_HANDLE_BITS     = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

endpackage

`default_nettype wire

[design/sorted_nearest_key_table_unit.sv]
// Top level: sorted key/handle table with ordered insert and nearest-key lookup.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | request   | i_in_valid / o_in_ready   | i_opcode, i_key, i_handle
//  out     | result    | o_out_valid / i_out_ready | o_found_key, o_found_handle,
//          |           |                           | o_table_empty, o_insert_refused
//
// One request at a time; the table sits in one memory with registered read data.
// Insert: entries above the new key shift up one slot and the new key fills the gap;
// a full table is refused. Lookup scans up from slot 0 to the first key not below the
// request (else the last), then gives the nearer of it and the entry below; a tie goes up.
// Reset clears the entry count and control state only; no clearing pass.
// A waiting result does not block the next request from being accepted.
`default_nettype none

module sorted_nearest_key_table_unit
    import sntk_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_opcode,
    input  wire logic [KEY_BITS-1:0]    i_key,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [KEY_BITS-1:0]    o_found_key,
    output logic      [HANDLE_BITS-1:0] o_found_handle,
    output logic                        o_table_empty,
    output logic                        o_insert_refused
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int EW = KEY_BITS + HANDLE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_LK_RD,
        S_LK_CMP,
        S_LK_PICK,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_idx;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [EW-1:0]          r_prev;
    logic [EW-1:0]          r_cand;
    logic [KEY_BITS-1:0]    r_below;
    logic [KEY_BITS-1:0]    r_above;
    logic [EW-1:0]          r_res;
    logic                   r_res_empty;
    logic                   r_res_refused;

    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [IW-1:0]          mem_raddr;
    logic [EW-1:0]          mem_rdata;
    logic [KEY_BITS-1:0]    rd_key;
    logic [KEY_BITS-1:0]    prev_key;
    logic [EW-1:0]          new_entry;
    logic                   in_fire;
    logic                   out_free;
    logic [CW-1:0]          idx_dec;

    assign rd_key    = mem_rdata[EW-1:HANDLE_BITS];
    assign prev_key  = r_prev[EW-1:HANDLE_BITS];
    assign new_entry = {r_key, r_handle};
    assign idx_dec   = r_idx - CW'(1);
    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[IW-1:0];
        mem_wdata = new_entry;
        mem_raddr = r_idx[IW-1:0];
        unique case (r_state)
            S_INS_RD: begin
                mem_raddr = idx_dec[IW-1:0];
                mem_we    = (r_idx == '0);
            end
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (r_key < rd_key) begin
                    mem_wdata = mem_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    sntk_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_key         <= i_key;
                        r_handle      <= i_handle;
                        r_res         <= '0;
                        r_res_empty   <= 1'b0;
                        r_res_refused <= 1'b0;
                        if (i_opcode == OP_INSERT) begin
                            r_idx <= r_count;
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                r_res_refused <= 1'b1;
                                r_state       <= S_EMIT;
                            end else begin
                                r_state <= S_INS_RD;
                            end
                        end else begin
                            r_idx <= '0;
                            if (r_count == '0) begin
                                r_res_empty <= 1'b1;
                                r_state     <= S_EMIT;
                            end else begin
                                r_state <= S_LK_RD;
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    if (r_idx == '0) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (r_key < rd_key) begin
                        r_idx   <= idx_dec;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_EMIT;
                    end
                end
                S_LK_RD: begin
                    r_state <= S_LK_CMP;
                end
                S_LK_CMP: begin
                    if (r_key > rd_key) begin
                        r_prev <= mem_rdata;
                        if ((r_idx + CW'(1)) == r_count) begin
                            r_res   <= mem_rdata;
                            r_state <= S_EMIT;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_LK_RD;
                        end
                    end else if (r_idx == '0) begin
                        r_res   <= mem_rdata;
                        r_state <= S_EMIT;
                    end else begin
                        r_cand  <= mem_rdata;
                        r_below <= r_key - prev_key;
                        r_above <= rd_key - r_key;
                        r_state <= S_LK_PICK;
                    end
                end
                S_LK_PICK: begin
                    r_res   <= (r_below < r_above) ? r_prev : r_cand;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_out_valid      <= 1'b1;
                        o_found_key      <= r_res[EW-1:HANDLE_BITS];
                        o_found_handle   <= r_res[HANDLE_BITS-1:0];
                        o_table_empty    <= r_res_empty;
                        o_insert_refused <= r_res_refused;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)))
        else $error("entry count moved by more than one");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_insert_refused) |-> (o_found_key == '0 && !o_table_empty))
        else $error("refused insert carries lookup data");
`endif

endmodule

`default_nettype wire

[design/sntk_ram.sv]
// Single-port-write, single-port-read table memory with registered read data.
`default_nettype none

module sntk_ram
    import sntk_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int WIDTH = KEY_BITS + DEF_HANDLE_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
